// ===== hdl/cubic_hermite_spline_eval_assert.svh =====
// assertion macros for the curve point evaluator
// no dependencies; taken in by the top level only
`ifndef CUBIC_HERMITE_SPLINE_EVAL_ASSERT_SVH
`define CUBIC_HERMITE_SPLINE_EVAL_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define CHS_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("curve evaluator check failed");

// next-cycle implication, quiet while in reset
`define CHS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("curve evaluator check failed");

`endif

// ===== hdl/chs_pkg.sv =====
// shared types and constants for the curve point evaluator
// no dependencies; used by every module of the block
package chs_pkg;

  // coordinate and parameter formats
  localparam int CoordBits = 32;
  localparam int FracBits  = 16;
  localparam int TBits     = FracBits + 1;

  // internal widths: doubled operands, weights, products, sums
  localparam int OpBits   = CoordBits + 1;
  localparam int WBits    = TBits + 3;
  localparam int ProdBits = OpBits + WBits;
  localparam int SumBits  = ProdBits + 2;
  localparam int ShBits   = SumBits - (FracBits + 1);

  // register levels from accepted word to result strobe
  localparam int PipeDepth = 7;

  localparam logic [TBits-1:0] TOne = TBits'(1) << FracBits;
  localparam logic [2*TBits-1:0] THalf = (2*TBits)'(1) << (FracBits - 1);
  localparam logic signed [SumBits-1:0] RoundHalf = SumBits'(1) << FracBits;
  localparam logic signed [CoordBits-1:0] MaxCoord = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] MinCoord = {1'b1, {(CoordBits-1){1'b0}}};

  typedef enum logic {
    CMD_HERMITE     = 1'b0,
    CMD_CATMULL_ROM = 1'b1
  } cmd_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [WBits-1:0] weight_t;

  // input word
  typedef struct packed {
    cmd_e             cmd;
    coord_t           start_x;
    coord_t           start_y;
    coord_t           end_x;
    coord_t           end_y;
    coord_t           aux_a_x;
    coord_t           aux_a_y;
    coord_t           aux_b_x;
    coord_t           aux_b_y;
    logic [TBits-1:0] t_param;
  } item_t;

  // result word
  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   saturated;
  } result_t;

  // basis weights, Q.FracBits
  typedef struct packed {
    weight_t h00;
    weight_t h01;
    weight_t h10;
    weight_t h11;
  } weights_t;

  // one axis result with its clip flag
  typedef struct packed {
    coord_t coord;
    logic   sat;
  } axis_res_t;

endpackage

// ===== hdl/chs_weights.sv =====
// basis weight generator: clamp t, square, cube, then the four weights
// depends on chs_pkg; three register levels
module chs_weights (
  input  logic                      clk_i,
  input  logic [chs_pkg::TBits-1:0] t_i,
  output chs_pkg::weights_t         w_o
);
  import chs_pkg::*;

  logic [TBits-1:0]   t_clamp;
  logic [2*TBits-1:0] sq_rnd;
  logic [2*TBits-1:0] cu_rnd;
  logic [TBits-1:0]   t1_q, t2_q, u2_q, u2b_q, u3_q;
  logic signed [WBits-1:0] t_s, u2_s, u3_s;
  weights_t w_d, w_q;

  // clamp to one, then rounded square
  assign t_clamp = (t_i > TOne) ? TOne : t_i;
  assign sq_rnd  = t_clamp * t_clamp + THalf;

  always_ff @(posedge clk_i) begin
    t1_q <= t_clamp;
    u2_q <= sq_rnd[FracBits +: TBits];
  end

  // rounded cube from the registered square
  assign cu_rnd = u2_q * t1_q + THalf;

  always_ff @(posedge clk_i) begin
    t2_q  <= t1_q;
    u2b_q <= u2_q;
    u3_q  <= cu_rnd[FracBits +: TBits];
  end

  // weights formed exactly from t, t^2 and t^3
  assign t_s  = $signed({{(WBits-TBits){1'b0}}, t2_q});
  assign u2_s = $signed({{(WBits-TBits){1'b0}}, u2b_q});
  assign u3_s = $signed({{(WBits-TBits){1'b0}}, u3_q});

  always_comb begin
    w_d.h00 = (u3_s <<< 1) - (u2_s <<< 1) - u2_s
              + $signed({{(WBits-TBits){1'b0}}, TOne});
    w_d.h01 = u3_s - (u2_s <<< 1) + t_s;
    w_d.h10 = (u2_s <<< 1) + u2_s - (u3_s <<< 1);
    w_d.h11 = u3_s - u2_s;
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign w_o = w_q;

endmodule

// ===== hdl/chs_axis.sv =====
// one coordinate axis: tangent forming, weighted sum, rounding, clipping
// depends on chs_pkg; weights arrive three levels after the operands
module chs_axis (
  input  logic               clk_i,
  input  logic               cr_i,
  input  chs_pkg::coord_t    p0_i,
  input  chs_pkg::coord_t    p1_i,
  input  chs_pkg::coord_t    a_i,
  input  chs_pkg::coord_t    b_i,
  input  chs_pkg::weights_t  w_i,
  output chs_pkg::axis_res_t res_o
);
  import chs_pkg::*;

  typedef logic signed [OpBits-1:0] op_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [SumBits-1:0] sum_t;

  typedef struct packed {
    op_t s0;
    op_t m0;
    op_t s1;
    op_t m1;
  } ops_t;

  ops_t ops_d;
  ops_t ops_q [3];
  prod_t prod_q [4];
  sum_t pair_q [2];
  sum_t sum_q;
  logic signed [ShBits-1:0] sh;
  logic [ShBits-CoordBits:0] upper;
  axis_res_t res_d, res_q;

  // doubled points and doubled tangents (one extra fraction bit)
  always_comb begin
    ops_d.s0 = {p0_i, 1'b0};
    ops_d.s1 = {p1_i, 1'b0};
    if (cr_i) begin
      ops_d.m0 = OpBits'(p1_i) - OpBits'(a_i);
      ops_d.m1 = OpBits'(b_i) - OpBits'(p0_i);
    end else begin
      ops_d.m0 = {a_i, 1'b0};
      ops_d.m1 = {b_i, 1'b0};
    end
  end

  // operand delay to meet the weights
  always_ff @(posedge clk_i) begin
    ops_q[0] <= ops_d;
    ops_q[1] <= ops_q[0];
    ops_q[2] <= ops_q[1];
  end

  // four products
  always_ff @(posedge clk_i) begin
    prod_q[0] <= ops_q[2].s0 * w_i.h00;
    prod_q[1] <= ops_q[2].m0 * w_i.h01;
    prod_q[2] <= ops_q[2].s1 * w_i.h10;
    prod_q[3] <= ops_q[2].m1 * w_i.h11;
  end

  // pair sums, rounding half folded in
  always_ff @(posedge clk_i) begin
    pair_q[0] <= SumBits'(prod_q[0]) + SumBits'(prod_q[1]);
    pair_q[1] <= SumBits'(prod_q[2]) + SumBits'(prod_q[3]) + RoundHalf;
  end

  // final sum
  always_ff @(posedge clk_i) begin
    sum_q <= pair_q[0] + pair_q[1];
  end

  // drop the fraction and clip to the coordinate range
  assign sh    = sum_q[SumBits-1:FracBits+1];
  assign upper = sh[ShBits-1:CoordBits-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      res_d.coord = sh[CoordBits-1:0];
      res_d.sat   = 1'b0;
    end else if (sh[ShBits-1]) begin
      res_d.coord = MinCoord;
      res_d.sat   = 1'b1;
    end else begin
      res_d.coord = MaxCoord;
      res_d.sat   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== hdl/cubic_hermite_spline_eval.sv =====
// channel   direction  handshake              payload
// command   in         start high, busy low   item_i   (chs_pkg::item_t)
// result    out        done_o strobe, 1 cycle result_o (chs_pkg::result_t)
//
// one word accepted every cycle; busy stays low, nothing holds the pipe
// each result passes in order through square, cube, weights,
// products, pair sums, final sum, clip and output register
// reset clears only the valid bits; payload registers run free
// the receiver cannot stall, so done_o is a plain one-cycle strobe
//
// depends on chs_pkg, chs_weights, chs_axis and the assertion header
`include "cubic_hermite_spline_eval_assert.svh"

module cubic_hermite_spline_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  chs_pkg::item_t    item_i,
  output logic              done_o,
  output chs_pkg::result_t  result_o
);
  import chs_pkg::*;

  logic accept;
  logic cr;
  logic [PipeDepth-1:0] valid_q, valid_d;
  weights_t w;
  axis_res_t res_x, res_y;

  // no stall source anywhere downstream
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cr     = (item_i.cmd == CMD_CATMULL_ROM);

  // valid bits travel alongside the data
  assign valid_d = {valid_q[PipeDepth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  chs_weights u_weights (
    .clk_i (clk_i),
    .t_i   (item_i.t_param),
    .w_o   (w)
  );

  chs_axis u_axis_x (
    .clk_i (clk_i),
    .cr_i  (cr),
    .p0_i  (item_i.start_x),
    .p1_i  (item_i.end_x),
    .a_i   (item_i.aux_a_x),
    .b_i   (item_i.aux_b_x),
    .w_i   (w),
    .res_o (res_x)
  );

  chs_axis u_axis_y (
    .clk_i (clk_i),
    .cr_i  (cr),
    .p0_i  (item_i.start_y),
    .p1_i  (item_i.end_y),
    .a_i   (item_i.aux_a_y),
    .b_i   (item_i.aux_b_y),
    .w_i   (w),
    .res_o (res_y)
  );

  // result word
  assign done_o             = valid_q[PipeDepth-1];
  assign result_o.out_x     = res_x.coord;
  assign result_o.out_y     = res_y.coord;
  assign result_o.saturated = res_x.sat | res_y.sat;

  // checks
  `CHS_ASSERT_NOW(a_done_follows_accept, clk_i, rst_ni, done_o, $past(accept, PipeDepth))
  `CHS_ASSERT_NOW(a_sat_at_limit, clk_i, rst_ni,
    done_o && result_o.saturated,
    (result_o.out_x == MaxCoord || result_o.out_x == MinCoord ||
     result_o.out_y == MaxCoord || result_o.out_y == MinCoord))
  `CHS_ASSERT_NOW(a_t_zero_gives_start, clk_i, rst_ni,
    done_o && ($past(item_i.t_param, PipeDepth) == '0),
    (result_o.out_x == $past(item_i.start_x, PipeDepth)) &&
    (result_o.out_y == $past(item_i.start_y, PipeDepth)) && !result_o.saturated)
  `CHS_ASSERT_NEXT(a_accept_starts_pipe, clk_i, rst_ni, accept, valid_q[0])

endmodule

// ===== tb/chs_checker.sv =====
// result checker for the curve point evaluator: predicts each result word
// from the accepted command words and compares, field by field, in order
// depends on chs_pkg only
module chs_checker
  import chs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  item_t       item_i,
  input  logic        done_o,
  input  result_t     result_o,
  output int unsigned fail_cnt,
  output int unsigned pending_cnt
);

  result_t     expected_points[$];
  int unsigned fails;
  int unsigned pending;

  assign fail_cnt    = fails;
  assign pending_cnt = pending;

  // one axis: weighted sum in Q.(FracBits+1), so the catmull-rom halving is exact
  function automatic axis_res_t axis_blend(bit cr, longint p0, longint p1, longint a,
                                           longint b, longint h00, longint h01,
                                           longint h10, longint h11);
    longint    m0;
    longint    m1;
    longint    acc;
    longint    rnd;
    axis_res_t res;
    m0  = cr ? (p1 - a) : (2 * a);
    m1  = cr ? (b - p0) : (2 * b);
    acc = 2 * p0 * h00 + m0 * h01 + 2 * p1 * h10 + m1 * h11;
    // round half up, then drop the fraction along with the extra bit
    rnd = (acc + (longint'(1) << FracBits)) >>> (FracBits + 1);
    res.sat = 1'b0;
    if (rnd > longint'(MaxCoord)) begin
      res.coord = MaxCoord;
      res.sat   = 1'b1;
    end else if (rnd < longint'(MinCoord)) begin
      res.coord = MinCoord;
      res.sat   = 1'b1;
    end else begin
      res.coord = coord_t'(rnd);
    end
    return res;
  endfunction

  // expected curve point for one command word
  function automatic result_t curve_point(item_t w);
    longint    t;
    longint    sq;
    longint    cu;
    longint    one;
    longint    half;
    longint    h00;
    longint    h01;
    longint    h10;
    longint    h11;
    bit        cr;
    axis_res_t ax;
    axis_res_t ay;
    result_t   r;
    one  = longint'(1) << FracBits;
    half = longint'(1) << (FracBits - 1);
    // parameter above one is clamped to one
    t    = (w.t_param > TOne) ? one : longint'(w.t_param);
    sq   = (t * t + half) >>> FracBits;
    cu   = (sq * t + half) >>> FracBits;
    h00  = 2 * cu - 3 * sq + one;
    h01  = cu - 2 * sq + t;
    h10  = -2 * cu + 3 * sq;
    h11  = cu - sq;
    cr   = (w.cmd == CMD_CATMULL_ROM);
    ax   = axis_blend(cr, longint'(w.start_x), longint'(w.end_x), longint'(w.aux_a_x),
                      longint'(w.aux_b_x), h00, h01, h10, h11);
    ay   = axis_blend(cr, longint'(w.start_y), longint'(w.end_y), longint'(w.aux_a_y),
                      longint'(w.aux_b_y), h00, h01, h10, h11);
    r.out_x     = ax.coord;
    r.out_y     = ay.coord;
    r.saturated = ax.sat | ay.sat;
    return r;
  endfunction

  // watch both channels; results are compared before new words are queued
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      expected_points.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (done_o) begin
        if (expected_points.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result word at %0t: x=%h y=%h sat=%b", $time,
                     result_o.out_x, result_o.out_y, result_o.saturated);
        end else begin
          want = expected_points.pop_front();
          if (result_o.out_x !== want.out_x || result_o.out_y !== want.out_y ||
              result_o.saturated !== want.saturated) begin
            fails++;
            if (fails <= 10)
              $display("mismatch at %0t: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                       $time, want.out_x, want.out_y, want.saturated,
                       result_o.out_x, result_o.out_y, result_o.saturated);
          end
        end
      end
      if (start && !busy)
        expected_points.push_back(curve_point(item_i));
      pending = expected_points.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the curve point evaluator testbench: clock, reset, command stimulus
// and verdict; depends on chs_pkg, chs_checker and cubic_hermite_spline_eval
module tb_top;
  import chs_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       item_i;
  logic        done_o;
  result_t     result_o;
  int unsigned fail_cnt;
  int unsigned pending_cnt;

  cubic_hermite_spline_eval DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  chs_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic item_t make_word(cmd_e cmd, coord_t p0x, coord_t p0y, coord_t p1x,
                                      coord_t p1y, coord_t ax, coord_t ay, coord_t bx,
                                      coord_t by, logic [TBits-1:0] t);
    item_t w;
    w.cmd     = cmd;
    w.start_x = p0x;
    w.start_y = p0y;
    w.end_x   = p1x;
    w.end_y   = p1y;
    w.aux_a_x = ax;
    w.aux_a_y = ay;
    w.aux_b_x = bx;
    w.aux_b_y = by;
    w.t_param = t;
    return w;
  endfunction

  // mostly modest coordinates, some across the whole range
  function automatic coord_t rand_coord();
    if ($urandom_range(99) < 40)
      return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
  endfunction

  function automatic item_t rand_word();
    item_t            w;
    int unsigned      pick;
    logic [TBits-1:0] t;
    pick = $urandom_range(99);
    if (pick < 80)
      t = TBits'($urandom_range(0, int'(TOne)));
    else if (pick < 90)
      t = $urandom_range(1) ? TOne : '0;
    else
      t = TBits'($urandom_range(0, (1 << TBits) - 1));
    w = make_word($urandom_range(1) ? CMD_CATMULL_ROM : CMD_HERMITE, rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), t);
    return w;
  endfunction

  // offer one word from the next falling edge until it is taken
  task automatic send_word(item_t w);
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= w;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_cycle();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // random gaps, roughly 28 idle cycles in a hundred
  task automatic maybe_idle();
    while ($urandom_range(99) < 28) idle_cycle();
  endtask

  // hold off until every queued result has come back
  task automatic drain();
    idle_cycle();
    while (pending_cnt != 0) idle_cycle();
  endtask

  initial begin
    item_t directed_words[$];
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words: ends of t, clamp of t, both modes, clipping both ways
    directed_words.push_back(make_word(CMD_HERMITE, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    directed_words.push_back(make_word(CMD_HERMITE, 32'h0001_0000, -32'sh0003_0000,
      32'h0002_0000, 32'h0005_8000, 32'h0004_0000, -32'sh0001_0000, -32'sh0002_0000,
      32'h0000_8000, '0));
    directed_words.push_back(make_word(CMD_HERMITE, 32'h0001_0000, -32'sh0003_0000,
      32'h0002_0000, 32'h0005_8000, 32'h0004_0000, -32'sh0001_0000, -32'sh0002_0000,
      32'h0000_8000, TOne));
    directed_words.push_back(make_word(CMD_HERMITE, 32'h0001_0000, -32'sh0003_0000,
      32'h0002_0000, 32'h0005_8000, 32'h0004_0000, -32'sh0001_0000, -32'sh0002_0000,
      32'h0000_8000, '1));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, 32'h0001_0000, 32'h0002_0000,
      32'h0003_0000, 32'h0001_0000, 0, 0, 32'h0004_0000, 32'h0003_0000,
      TBits'(TOne + 1'b1)));
    directed_words.push_back(make_word(CMD_HERMITE, 32'h0001_0000, 32'h0002_0000,
      32'h0003_0000, 32'h0001_0000, 32'h0001_0000, -32'sh0001_0000, 32'h0002_0000,
      32'h0000_0001, TBits'(32768)));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, 32'h0001_0000, 32'h0002_0000,
      32'h0003_0000, 32'h0001_0000, -32'sh0001_0000, 32'h0003_0000, 32'h0005_0000,
      32'h0000_0001, TBits'(32768)));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, 32'h0000_0001, -32'sh1, 32'h0000_0002,
      32'h0000_0003, -32'sh3, 32'h0000_0005, 32'h0000_0007, -32'sh7, TBits'(1)));
    // clipping high on x, low on y
    directed_words.push_back(make_word(CMD_HERMITE, MaxCoord, MinCoord, MaxCoord, MinCoord,
      MaxCoord, MinCoord, MinCoord, MaxCoord, TBits'(16384)));
    // clipping low on x only
    directed_words.push_back(make_word(CMD_HERMITE, MinCoord, 0, MinCoord, 0, MinCoord, 0,
      MaxCoord, 0, TBits'(49152)));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, MaxCoord, MaxCoord, MinCoord,
      MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord, TBits'(32768)));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, MinCoord, MaxCoord, MaxCoord,
      MinCoord, MaxCoord, MinCoord, MinCoord, MaxCoord, TBits'(21845)));
    directed_words.push_back(make_word(CMD_HERMITE, MinCoord, MinCoord, MinCoord, MinCoord,
      MinCoord, MinCoord, MinCoord, MinCoord, TBits'(TOne - 1'b1)));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, MaxCoord, MaxCoord, MaxCoord,
      MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord, '1));
    directed_words.push_back(make_word(CMD_HERMITE, MaxCoord, MaxCoord, MaxCoord, MaxCoord,
      MaxCoord, MaxCoord, MaxCoord, MaxCoord, TBits'(1)));
    directed_words.push_back(make_word(CMD_CATMULL_ROM, -32'sh1, -32'sh1, -32'sh1, -32'sh1,
      -32'sh1, -32'sh1, -32'sh1, -32'sh1, TBits'(65535)));

    foreach (directed_words[i]) begin
      maybe_idle();
      send_word(directed_words[i]);
    end
    drain();

    // random words; a stretch in the middle runs back to back
    for (int n = 0; n < 450; n++) begin
      if (n == 300)
        drain();
      if (n < 150 || n >= 250)
        maybe_idle();
      send_word(rand_word());
    end
    idle_cycle();

    // let the pipe empty, then keep watching for stray words
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (PipeDepth + 4) @(negedge clk_i);
    if (fail_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
